// File: src/prld_pkg.sv
// ----------------------------------------------------------------------------
// prld_pkg
// Shared types and constants for the picture run-length decoder.
// ----------------------------------------------------------------------------
package prld_pkg;

    // Default and largest supported picture side
    localparam int MaxSideDefault = 255;

    // Configuration address width, register selects on paddr[2] and side reset value
    localparam int            CfgAddrW    = 3;
    localparam logic [0:0]    REG_SIDE    = 1'b0;
    localparam logic [0:0]    REG_RAW     = 1'b1;
    localparam logic [7:0]    SIDE_RESET  = 8'd16;

    // Run kinds
    typedef logic [1:0] t_run_kind;
    localparam t_run_kind KIND_NONE    = 2'd0;
    localparam t_run_kind KIND_FILL    = 2'd1;
    localparam t_run_kind KIND_LITERAL = 2'd2;
    localparam t_run_kind KIND_COPY    = 2'd3;

    // Header byte bounds and run scaling
    localparam logic [7:0]  HDR_LIT_LO  = 8'd85;
    localparam logic [7:0]  HDR_COPY_LO = 8'd170;
    localparam logic [12:0] LIT_BIAS    = 13'd84;
    localparam logic [12:0] COPY_BIAS   = 13'd169;
    localparam logic [12:0] RUN_SCALE   = 13'd85;

    // Result flags, highest bit first
    typedef struct packed {
        logic format_error;
        logic need_byte;
        logic pixel_valid;
    } t_flags;

endpackage

// File: src/picture_run_length_decoder_unit.sv
// ----------------------------------------------------------------------------
// picture_run_length_decoder_unit
// Decodes a square 8-bit picture from a run-length coded byte stream; the
// previous row is kept in a line store for copy-above runs.
// ----------------------------------------------------------------------------
// The result of an accepted input transfer is registered in the output
//   register.
// Throughput: one item per cycle unless m_tready stalls the output; the line store
//   reads ahead at the next column, write-to-read forwarded; copies never wait.
// Reset (synchronous, active low): run state, pixel and column counters and
//   the output valid, flags and last clear; side returns to 16, raw mode off.
//   The line store is not cleared; the first row never reads it.
// ----------------------------------------------------------------------------
module picture_run_length_decoder_unit #(
    parameter int MAX_SIDE = prld_pkg::MaxSideDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tuser,   // [0] operation
    // Output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] pixel
    output logic [2:0]                    m_tuser,   // [0] pixel_valid [1] need_byte
                                                     // [2] format_error
    output logic                          m_tlast,   // last_pixel
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prld_pkg::CfgAddrW-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(MAX_SIDE);
    localparam logic [8:0] MaxSideW = 9'(MAX_SIDE);

    // Configuration registers
    logic [7:0] r_side;
    logic       r_raw;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= prld_pkg::SIDE_RESET;
            r_raw  <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == prld_pkg::REG_SIDE) begin
                r_side <= pwdata[7:0];
            end else begin
                r_raw <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == prld_pkg::REG_SIDE) begin
            prdata = {24'd0, r_side};
        end else begin
            prdata = {31'd0, r_raw};
        end
    end

    // Decoder state
    logic [12:0]          r_run_left, n_run_left;
    prld_pkg::t_run_kind  r_kind,     n_kind;
    logic                 r_await,    n_await;
    logic [6:0]           r_hdr,      n_hdr;
    logic [7:0]           r_color,    n_color;
    logic [15:0]          r_pcount,   n_pcount;
    logic [7:0]           r_column,   n_column;

    // Output register
    logic                 r_out_valid;
    logic [7:0]           r_out_pixel, n_out_pixel;
    prld_pkg::t_flags     r_out_flags, n_out_flags;
    logic                 r_out_last,  n_out_last;

    // Line store forwarding
    logic                 r_fwd_hit;
    logic [7:0]           r_fwd_data;
    logic [7:0]           ram_rdata;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;

    logic                 accept;
    logic [7:0]           eff_side;
    logic [15:0]          area;
    logic                 at_last;
    logic [7:0]           above;
    logic [8:0]           col_inc;
    logic [12:0]          hdr_ext;
    logic [12:0]          fill_len;
    logic [12:0]          copy_len;
    logic                 emit;
    logic [7:0]           emit_val;

    assign s_tready = !r_out_valid || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Side, picture area and end-of-picture test
    assign eff_side = ({1'b0, r_side} > MaxSideW) ? MaxSideW[7:0] : r_side;
    assign area     = eff_side * eff_side;
    assign at_last  = ({1'b0, r_pcount} + 17'd1) >= {1'b0, area};

    // Pixel above, zero in the first row
    assign above = (r_pcount < {8'd0, eff_side} || {1'b0, r_column} >= MaxSideW)
                   ? 8'd0 : (r_fwd_hit ? r_fwd_data : ram_rdata);

    assign col_inc  = {1'b0, r_column} + 9'd1;
    assign hdr_ext  = {6'd0, r_hdr};
    assign fill_len = ({1'b0, r_kind} == {1'b0, prld_pkg::KIND_FILL} && s_tdata == r_color)
                      ? 13'((hdr_ext + 13'd1) * prld_pkg::RUN_SCALE)
                      : hdr_ext + 13'd2;
    assign copy_len = (r_kind == prld_pkg::KIND_COPY)
                      ? 13'(({5'd0, s_tdata} - prld_pkg::COPY_BIAS) * prld_pkg::RUN_SCALE)
                      : {5'd0, s_tdata} - prld_pkg::COPY_BIAS;

    // Item decode: next state and result
    always_comb begin
        n_run_left  = r_run_left;
        n_kind      = r_kind;
        n_await     = r_await;
        n_hdr       = r_hdr;
        n_color     = r_color;
        n_pcount    = r_pcount;
        n_column    = r_column;
        n_out_flags = '0;
        n_out_last  = 1'b0;
        emit        = 1'b0;
        emit_val    = 8'd0;

        if (accept) begin
            if (s_tuser) begin
                // Tick: drain one fill or copy pixel, else flag that a byte is needed
                if (!r_raw && !r_await && r_run_left != 13'd0 &&
                    (r_kind == prld_pkg::KIND_FILL || r_kind == prld_pkg::KIND_COPY)) begin
                    emit       = 1'b1;
                    emit_val   = (r_kind == prld_pkg::KIND_FILL) ? r_color : above;
                    n_run_left = r_run_left - 13'd1;
                end else begin
                    n_out_flags.need_byte = 1'b1;
                end
            end else if (r_raw) begin
                emit     = 1'b1;
                emit_val = s_tdata;
            end else if (r_await) begin
                // Value byte of a homogeneous run
                n_await    = 1'b0;
                n_kind     = prld_pkg::KIND_FILL;
                n_color    = s_tdata;
                n_run_left = fill_len - 13'd1;
                emit       = 1'b1;
                emit_val   = s_tdata;
            end else if (r_run_left != 13'd0) begin
                if (r_kind == prld_pkg::KIND_LITERAL) begin
                    n_run_left = r_run_left - 13'd1;
                    emit       = 1'b1;
                    emit_val   = s_tdata;
                end else begin
                    n_out_flags.format_error = 1'b1;
                end
            end else if (s_tdata < prld_pkg::HDR_LIT_LO) begin
                n_hdr   = s_tdata[6:0];
                n_await = 1'b1;
            end else if (s_tdata < prld_pkg::HDR_COPY_LO) begin
                n_kind     = prld_pkg::KIND_LITERAL;
                n_run_left = {5'd0, s_tdata} - prld_pkg::LIT_BIAS;
            end else begin
                n_kind     = prld_pkg::KIND_COPY;
                n_run_left = copy_len - 13'd1;
                emit       = 1'b1;
                emit_val   = above;
            end

            // Pixel bookkeeping
            if (emit) begin
                n_out_flags.pixel_valid = 1'b1;
                n_column = (col_inc >= {1'b0, eff_side}) ? 8'd0 : col_inc[7:0];
                if (at_last) begin
                    n_out_last = 1'b1;
                    n_run_left = '0;
                    n_kind     = prld_pkg::KIND_NONE;
                    n_await    = 1'b0;
                    n_hdr      = '0;
                    n_color    = '0;
                    n_pcount   = '0;
                    n_column   = '0;
                end else begin
                    n_pcount = r_pcount + 16'd1;
                end
            end
        end
        n_out_pixel = emit_val;
    end

    // Line store: write emitted pixel, read ahead at the next column
    assign ram_we    = emit && ({1'b0, r_column} < MaxSideW);
    assign ram_waddr = r_column[AW-1:0];
    assign ram_raddr = n_column[AW-1:0];

    prld_ram #(
        .WIDTH (8),
        .DEPTH (MAX_SIDE)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (emit_val),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // State, forwarding and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_left  <= '0;
            r_kind      <= prld_pkg::KIND_NONE;
            r_await     <= 1'b0;
            r_hdr       <= '0;
            r_color     <= '0;
            r_pcount    <= '0;
            r_column    <= '0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_flags <= '0;
            r_out_last  <= 1'b0;
        end else begin
            r_run_left <= n_run_left;
            r_kind     <= n_kind;
            r_await    <= n_await;
            r_hdr      <= n_hdr;
            r_color    <= n_color;
            r_pcount   <= n_pcount;
            r_column   <= n_column;
            r_fwd_hit  <= ram_we && (ram_waddr == ram_raddr);
            if (accept) begin
                r_out_valid <= 1'b1;
                r_out_flags <= n_out_flags;
                r_out_last  <= n_out_last;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= emit_val;
        if (accept) begin
            r_out_pixel <= n_out_pixel;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_pixel;
    assign m_tuser  = r_out_flags;
    assign m_tlast  = r_out_last;

    // Checks
    a_await_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> (r_run_left == 13'd0))
        else $error("value byte awaited while a run is pending");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> $onehot0(m_tuser))
        else $error("more than one result flag set");

    a_last_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("last flag without a pixel");

    a_picture_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && at_last) |=> (r_pcount == 16'd0 && r_column == 8'd0))
        else $error("decoder did not restart after the last pixel");

endmodule

// File: src/prld_ram.sv
// ----------------------------------------------------------------------------
// prld_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module prld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 255
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
